>>> sv/triangle_tangent_generator_unit_assert.svh
`ifndef TRIANGLE_TANGENT_GENERATOR_UNIT_ASSERT_SVH
`define TRIANGLE_TANGENT_GENERATOR_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define TTG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define TTG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ttg_pkg.sv
package ttg_pkg;

    // Result format
    localparam int OUT_W      = 32;
    localparam int QUOT_SHIFT = 20;
    localparam int MAG_BITS   = OUT_W - 1;
    localparam int PRE_SHIFT  = MAG_BITS - QUOT_SHIFT;
    localparam int DIV_STEPS  = MAG_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic signed [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

    // Corner count codes
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    // Field slots of one queued triangle
    localparam int ENT_DV2   = 0;
    localparam int ENT_DU2   = 1;
    localparam int ENT_DV1   = 2;
    localparam int ENT_DU1   = 3;
    localparam int ENT_E2Z   = 4;
    localparam int ENT_E2Y   = 5;
    localparam int ENT_E2X   = 6;
    localparam int ENT_E1Z   = 7;
    localparam int ENT_E1Y   = 8;
    localparam int ENT_E1X   = 9;
    localparam int ENT_COUNT = 10;

    localparam int AXES        = 3;
    localparam int QUEUE_DEPTH = 2;

    // Multiply sequence: determinant, then x, y, z numerators, then drain
    localparam logic [2:0] MUL_DET   = 3'd0;
    localparam logic [2:0] MUL_NUM_X = 3'd1;
    localparam logic [2:0] MUL_NUM_Y = 3'd2;
    localparam logic [2:0] MUL_NUM_Z = 3'd3;
    localparam logic [2:0] MUL_DRAIN = 3'd4;

    localparam logic [1:0] LAST_RESULT = 2'd2;

    typedef enum logic [4:0] {
        BK_IDLE = 5'b00001,
        BK_MUL  = 5'b00010,
        BK_PREP = 5'b00100,
        BK_DIV  = 5'b01000,
        BK_EMIT = 5'b10000
    } ttg_back_state_t;

endpackage

>>> sv/ttg_if.sv
interface ttg_in_if #(parameter int COORD_BITS = 16) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic signed [COORD_BITS-1:0] tex_u;
    logic signed [COORD_BITS-1:0] tex_v;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output tex_u, output tex_v, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input tex_u, input tex_v, output ready);
endinterface

interface ttg_out_if import ttg_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] tangent_x;
    logic signed [OUT_W-1:0] tangent_y;
    logic signed [OUT_W-1:0] tangent_z;
    logic                    degenerate;
    logic                    last;

    modport source (output valid, output tangent_x, output tangent_y, output tangent_z,
                    output degenerate, output last, input ready);
    modport sink   (input valid, input tangent_x, input tangent_y, input tangent_z,
                    input degenerate, input last, output ready);
endinterface

>>> sv/ttg_front.sv
module ttg_front import ttg_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    ttg_in_if.sink                                corner,
    output logic                                  push_valid,
    input  logic                                  push_ready,
    output logic [ENT_COUNT*(COORD_BITS+1)-1:0]   push_data
);

    localparam int DW = COORD_BITS + 1;

    logic [1:0]                   count_reg, count_next;
    logic signed [COORD_BITS-1:0] p1_reg [AXES];
    logic signed [COORD_BITS-1:0] p2_reg [AXES];
    logic signed [COORD_BITS-1:0] u1_reg, v1_reg, u2_reg, v2_reg;
    logic signed [COORD_BITS-1:0] pos [AXES];
    logic signed [DW-1:0]         ent [ENT_COUNT];
    logic                         xfer;

    assign pos[0] = corner.pos_x;
    assign pos[1] = corner.pos_y;
    assign pos[2] = corner.pos_z;

    // Third corner needs a queue slot; the first two are only held
    assign corner.ready = (count_reg != CNT_TWO) || push_ready;
    assign push_valid   = corner.valid && (count_reg == CNT_TWO);
    assign xfer         = corner.valid && corner.ready;

    // Form edges and texture deltas against the first corner
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            ent[ENT_E1X-i] = DW'(p2_reg[i]) - DW'(p1_reg[i]);
            ent[ENT_E2X-i] = DW'(pos[i]) - DW'(p1_reg[i]);
        end
        ent[ENT_DU1] = DW'(u2_reg) - DW'(u1_reg);
        ent[ENT_DV1] = DW'(v2_reg) - DW'(v1_reg);
        ent[ENT_DU2] = DW'(corner.tex_u) - DW'(u1_reg);
        ent[ENT_DV2] = DW'(corner.tex_v) - DW'(v1_reg);
        for (int k = 0; k < ENT_COUNT; k++)
        begin
            push_data[k*DW +: DW] = ent[k];
        end
    end

    // Advance the corner count on each transfer
    always_comb
    begin
        count_next = count_reg;
        if (xfer)
        begin
            case (count_reg)
                CNT_NONE: count_next = CNT_ONE;
                CNT_ONE:  count_next = CNT_TWO;
                default:  count_next = CNT_NONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_NONE;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Hold the first two corners
    always_ff @(posedge clk)
    begin
        if (xfer && (count_reg == CNT_NONE))
        begin
            for (int i = 0; i < AXES; i++)
            begin
                p1_reg[i] <= pos[i];
            end
            u1_reg <= corner.tex_u;
            v1_reg <= corner.tex_v;
        end
        if (xfer && (count_reg == CNT_ONE))
        begin
            for (int i = 0; i < AXES; i++)
            begin
                p2_reg[i] <= pos[i];
            end
            u2_reg <= corner.tex_u;
            v2_reg <= corner.tex_v;
        end
    end

endmodule

>>> sv/ttg_queue.sv
module ttg_queue import ttg_pkg::*; #(
    parameter int WIDTH = 170
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/ttg_div_lane.sv
module ttg_div_lane import ttg_pkg::*; #(
    parameter int MAG_W = 35,
    parameter int DEN_W = 46
) (
    input  logic                    clk,
    input  logic                    load,
    input  logic                    step,
    input  logic [MAG_W-1:0]        num_mag,
    input  logic                    neg,
    input  logic [DEN_W-1:0]        den_shift,
    output logic signed [OUT_W-1:0] quot
);

    logic [DEN_W-1:0]    rem_reg;
    logic [MAG_BITS-1:0] q_reg;
    logic                ovf_reg, neg_reg;
    logic [DEN_W:0]      rem_dbl;
    logic                take;
    logic [OUT_W-1:0]    mag;

    assign rem_dbl = {rem_reg, 1'b0};
    assign take    = (rem_dbl >= {1'b0, den_shift});
    assign mag     = {1'b0, q_reg};

    // Restoring division, one quotient bit per step
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= DEN_W'(num_mag);
            q_reg   <= '0;
            ovf_reg <= (DEN_W'(num_mag) >= den_shift);
            neg_reg <= neg;
        end
        else if (step)
        begin
            if (take)
            begin
                rem_reg <= DEN_W'(rem_dbl - {1'b0, den_shift});
            end
            else
            begin
                rem_reg <= DEN_W'(rem_dbl);
            end
            q_reg <= {q_reg[MAG_BITS-2:0], take};
        end
    end

    // Apply sign and saturate
    always_comb
    begin
        if (ovf_reg)
        begin
            quot = neg_reg ? SAT_NEG : SAT_POS;
        end
        else if (neg_reg)
        begin
            quot = $signed(OUT_W'(0) - mag);
        end
        else
        begin
            quot = $signed(mag);
        end
    end

endmodule

>>> sv/ttg_back.sv
module ttg_back import ttg_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  logic [ENT_COUNT*(COORD_BITS+1)-1:0] pop_data,
    ttg_out_if.source                           tangent,
    output logic                                idle
);

    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * DW;
    localparam int SW  = PW + 1;
    localparam int DSW = SW + PRE_SHIFT;

    ttg_back_state_t       state_reg, state_next;
    logic signed [DW-1:0]  ent_reg [ENT_COUNT];
    logic [2:0]            mul_idx_reg;
    logic signed [PW-1:0]  prod_a_reg, prod_b_reg;
    logic signed [SW-1:0]  res_reg [AXES+1];
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [1:0]            emit_cnt_reg;
    logic                  degen_reg;
    logic                  out_valid_reg, out_last_reg, out_degen_reg;
    logic signed [OUT_W-1:0] out_t_reg [AXES];

    logic signed [DW-1:0]  op_a, op_b, op_c, op_d;
    logic [1:0]            res_slot;
    logic signed [SW-1:0]  det;
    logic [SW-1:0]         det_mag;
    logic [DSW-1:0]        den_shift;
    logic [SW-1:0]         num_mag [AXES];
    logic                  num_neg [AXES];
    logic signed [OUT_W-1:0] lane_quot [AXES];
    logic                  lane_load, lane_step, out_free;

    assign pop_ready = (state_reg == BK_IDLE);
    assign idle      = (state_reg == BK_IDLE);
    assign lane_load = (state_reg == BK_PREP);
    assign lane_step = (state_reg == BK_DIV);
    assign out_free  = !out_valid_reg || tangent.ready;
    assign res_slot  = 2'(mul_idx_reg - 3'd1);

    // Select multiplier operands for the current product pair
    always_comb
    begin
        case (mul_idx_reg)
            MUL_DET:
            begin
                op_a = ent_reg[ENT_DU1];
                op_b = ent_reg[ENT_DV2];
                op_c = ent_reg[ENT_DU2];
                op_d = ent_reg[ENT_DV1];
            end
            MUL_NUM_X:
            begin
                op_a = ent_reg[ENT_DV2];
                op_b = ent_reg[ENT_E1X];
                op_c = ent_reg[ENT_DV1];
                op_d = ent_reg[ENT_E2X];
            end
            MUL_NUM_Y:
            begin
                op_a = ent_reg[ENT_DV2];
                op_b = ent_reg[ENT_E1Y];
                op_c = ent_reg[ENT_DV1];
                op_d = ent_reg[ENT_E2Y];
            end
            MUL_NUM_Z:
            begin
                op_a = ent_reg[ENT_DV2];
                op_b = ent_reg[ENT_E1Z];
                op_c = ent_reg[ENT_DV1];
                op_d = ent_reg[ENT_E2Z];
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
                op_c = '0;
                op_d = '0;
            end
        endcase
    end

    // Magnitudes and signs for the divider lanes
    always_comb
    begin
        det       = res_reg[0];
        det_mag   = det[SW-1] ? SW'(-det) : SW'(det);
        den_shift = {det_mag, {PRE_SHIFT{1'b0}}};
        for (int i = 0; i < AXES; i++)
        begin
            num_mag[i] = res_reg[i+1][SW-1] ? SW'(-res_reg[i+1]) : SW'(res_reg[i+1]);
            num_neg[i] = res_reg[i+1][SW-1] ^ det[SW-1];
        end
    end

    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        ttg_div_lane #(
            .MAG_W (SW),
            .DEN_W (DSW)
        ) u_lane (
            .clk       (clk),
            .load      (lane_load),
            .step      (lane_step),
            .num_mag   (num_mag[g]),
            .neg       (num_neg[g]),
            .den_shift (den_shift),
            .quot      (lane_quot[g])
        );
    end

    // Sequence one triangle
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (pop_valid) state_next = BK_MUL;
            BK_MUL:  if (mul_idx_reg == MUL_DRAIN) state_next = BK_PREP;
            BK_PREP: state_next = BK_DIV;
            BK_DIV:  if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) state_next = BK_EMIT;
            BK_EMIT: if (out_free && (emit_cnt_reg == LAST_RESULT)) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            mul_idx_reg   <= MUL_DET;
            div_cnt_reg   <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_MUL)
            begin
                mul_idx_reg <= (mul_idx_reg == MUL_DRAIN) ? MUL_DET : mul_idx_reg + 3'd1;
            end
            if (state_reg == BK_DIV)
            begin
                div_cnt_reg <= (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) ? '0
                                                                           : div_cnt_reg + 1'b1;
            end
            if ((state_reg == BK_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
                emit_cnt_reg  <= (emit_cnt_reg == LAST_RESULT) ? '0 : emit_cnt_reg + 2'd1;
            end
            else if (tangent.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == BK_IDLE) && pop_valid)
        begin
            for (int k = 0; k < ENT_COUNT; k++)
            begin
                ent_reg[k] <= pop_data[k*DW +: DW];
            end
        end
        if (state_reg == BK_MUL)
        begin
            prod_a_reg <= op_a * op_b;
            prod_b_reg <= op_c * op_d;
            if (mul_idx_reg != MUL_DET)
            begin
                res_reg[res_slot] <= SW'(prod_a_reg) - SW'(prod_b_reg);
            end
        end
        if (state_reg == BK_PREP)
        begin
            degen_reg <= (det == '0);
        end
        if ((state_reg == BK_EMIT) && out_free)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                out_t_reg[i] <= degen_reg ? '0 : lane_quot[i];
            end
            out_degen_reg <= degen_reg;
            out_last_reg  <= (emit_cnt_reg == LAST_RESULT);
        end
    end

    assign tangent.valid      = out_valid_reg;
    assign tangent.tangent_x  = out_t_reg[0];
    assign tangent.tangent_y  = out_t_reg[1];
    assign tangent.tangent_z  = out_t_reg[2];
    assign tangent.degenerate = out_degen_reg;
    assign tangent.last       = out_last_reg;

endmodule

>>> sv/triangle_tangent_generator_unit.sv
// Channel   Role    Payload
// corner    sink    pos_x, pos_y, pos_z, tex_u, tex_v (COORD_BITS each, signed)
// tangent   source  tangent_x, tangent_y, tangent_z (32, signed), degenerate, last
//
// The first two corners of a triangle are taken one per cycle; the third waits only
// for a free slot in the two-entry triangle queue.
// The back end pops a triangle, runs 5 multiply steps and a prepare step, then 31 radix-2
// divide steps (three lanes in parallel) and 3 results; it pops the next one only when idle.
// Results leave through an output register; a stalled sink holds the back end in
// its result phase while the front end keeps filling the queue.
// rst_n clears the corner count, the queue occupancy and the sequencer; no sweep.

`include "triangle_tangent_generator_unit_assert.svh"

module triangle_tangent_generator_unit import ttg_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    ttg_in_if.sink    corner,
    ttg_out_if.source tangent
);

    localparam int ENT_W = ENT_COUNT * (COORD_BITS + 1);

    logic             f_push_valid, f_push_ready;
    logic [ENT_W-1:0] f_push_data;
    logic             q_pop_valid, q_pop_ready;
    logic [ENT_W-1:0] q_pop_data;
    logic             back_idle;
    logic             degen_shown, tangent_zero;
    logic             last_xfer, last_shown;

    ttg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .corner     (corner),
        .push_valid (f_push_valid),
        .push_ready (f_push_ready),
        .push_data  (f_push_data)
    );

    ttg_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_push_valid),
        .push_ready (f_push_ready),
        .push_data  (f_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    ttg_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data),
        .tangent   (tangent),
        .idle      (back_idle)
    );

    // Observation terms for the checks below
    assign degen_shown  = tangent.valid && tangent.degenerate;
    assign tangent_zero = (tangent.tangent_x == '0) && (tangent.tangent_y == '0)
                          && (tangent.tangent_z == '0);
    assign last_xfer    = tangent.valid && tangent.ready && tangent.last;
    assign last_shown   = tangent.valid && tangent.last;

    // A degenerate triangle carries zero tangents
    `TTG_ASSERT_NOW(a_degen_zero, degen_shown, tangent_zero, "degenerate result with nonzero tangent")

    // Two last results never follow each other directly
    `TTG_ASSERT_NEXT(a_last_spacing, last_xfer, !last_shown, "back-to-back last results")

    // An idle back end picks up a queued triangle at once
    `TTG_ASSERT_NEXT(a_back_pickup, q_pop_valid && back_idle, !back_idle, "queued triangle not taken")

endmodule

>>> sim/tb_triangle_tangent_generator_unit.sv
`timescale 1ns / 100ps

module tb_triangle_tangent_generator_unit;
    import ttg_pkg::*;

    localparam int COORD_BITS = 16;
    localparam int FRAC_SHIFT = 20;

    typedef struct {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic signed [COORD_BITS-1:0] tex_u;
        logic signed [COORD_BITS-1:0] tex_v;
    } corner_t;

    typedef struct {
        logic signed [OUT_W-1:0] tangent_x;
        logic signed [OUT_W-1:0] tangent_y;
        logic signed [OUT_W-1:0] tangent_z;
        logic                    degenerate;
        logic                    last;
    } tangent_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   steady = 1'b0;

    ttg_in_if #(.COORD_BITS(COORD_BITS)) corner_ch ();
    ttg_out_if tangent_ch ();

    triangle_tangent_generator_unit #(.COORD_BITS(COORD_BITS)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .corner  (corner_ch),
        .tangent (tangent_ch)
    );

    // Position component by axis index
    function automatic longint axis_of(corner_t c, int k);
        case (k)
            0:       return longint'(c.pos_x);
            1:       return longint'(c.pos_y);
            default: return longint'(c.pos_z);
        endcase
    endfunction

    // num * 2^20 / den, truncated toward zero, clamped to the 32-bit rails
    function automatic logic signed [OUT_W-1:0] scaled_ratio(longint num, longint den);
        bit              neg;
        longint unsigned n;
        longint unsigned d;
        longint unsigned mag;
        longint          signed_mag;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? longint'(-num) : longint'(num);
        d = (den < 0) ? longint'(-den) : longint'(den);
        if (n / d >= (64'd1 << (OUT_W - FRAC_SHIFT)))
            mag = 64'd1 << OUT_W;
        else
            mag = (n << FRAC_SHIFT) / d;
        if (neg)
        begin
            if (mag >= 64'h8000_0000)
                return SAT_NEG;
            signed_mag = -longint'(mag);
            return signed_mag[OUT_W-1:0];
        end
        if (mag > 64'h7FFF_FFFF)
            return SAT_POS;
        return mag[OUT_W-1:0];
    endfunction

    class tangent_scoreboard;
        tangent_t expected_tangents[$];
        corner_t  held[2];
        int       held_count       = 0;
        int       error_count      = 0;
        int       corners          = 0;
        int       triangles        = 0;
        int       degenerate_count = 0;
        int       railed_count     = 0;
        int       checked          = 0;

        function int pending();
            return expected_tangents.size();
        endfunction

        // Hold the first two corners; on the third, predict three tangents
        function void take_corner(corner_t c);
            longint                  e1;
            longint                  e2;
            longint                  du1;
            longint                  dv1;
            longint                  du2;
            longint                  dv2;
            longint                  det;
            logic signed [OUT_W-1:0] axis_t[3];
            tangent_t                t;
            corners++;
            if (held_count < 2)
            begin
                held[held_count] = c;
                held_count++;
                return;
            end
            held_count = 0;
            triangles++;
            du1 = longint'(held[1].tex_u) - longint'(held[0].tex_u);
            dv1 = longint'(held[1].tex_v) - longint'(held[0].tex_v);
            du2 = longint'(c.tex_u) - longint'(held[0].tex_u);
            dv2 = longint'(c.tex_v) - longint'(held[0].tex_v);
            det = du1 * dv2 - du2 * dv1;
            for (int k = 0; k < 3; k++)
            begin
                e1 = axis_of(held[1], k) - axis_of(held[0], k);
                e2 = axis_of(c, k) - axis_of(held[0], k);
                axis_t[k] = (det == 0) ? '0 : scaled_ratio(dv2 * e1 - dv1 * e2, det);
            end
            if (det == 0)
                degenerate_count++;
            if (axis_t[0] inside {SAT_POS, SAT_NEG} || axis_t[1] inside {SAT_POS, SAT_NEG}
                || axis_t[2] inside {SAT_POS, SAT_NEG})
                railed_count++;
            t.tangent_x  = axis_t[0];
            t.tangent_y  = axis_t[1];
            t.tangent_z  = axis_t[2];
            t.degenerate = (det == 0);
            for (int k = 0; k < 3; k++)
            begin
                t.last = (k == 2);
                expected_tangents.insert(expected_tangents.size(), t);
            end
        endfunction

        function void compare_field(string name, logic signed [OUT_W-1:0] want,
                                    logic signed [OUT_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                error_count++;
            end
        endfunction

        function void check_tangent(tangent_t got);
            tangent_t want;
            checked++;
            if (expected_tangents.size() == 0)
            begin
                $error("tangent with nothing outstanding: x %0d y %0d z %0d",
                       got.tangent_x, got.tangent_y, got.tangent_z);
                error_count++;
                return;
            end
            want = expected_tangents.pop_front();
            compare_field("tangent_x", want.tangent_x, got.tangent_x);
            compare_field("tangent_y", want.tangent_y, got.tangent_y);
            compare_field("tangent_z", want.tangent_z, got.tangent_z);
            compare_field("degenerate", want.degenerate, got.degenerate);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    tangent_scoreboard sb = new();

    // Clock: 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Check every tangent transfer
    always @(posedge clk)
    begin
        tangent_t got;
        if (rst_n && tangent_ch.valid && tangent_ch.ready)
        begin
            got.tangent_x  = tangent_ch.tangent_x;
            got.tangent_y  = tangent_ch.tangent_y;
            got.tangent_z  = tangent_ch.tangent_z;
            got.degenerate = tangent_ch.degenerate;
            got.last       = tangent_ch.last;
            sb.check_tangent(got);
        end
    end

    // Drive sink ready: short random stalls, an occasional long one
    initial
    begin
        tangent_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!steady && $urandom_range(0, 199) == 0)
            begin
                tangent_ch.ready <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            tangent_ch.ready <= steady || ($urandom_range(0, 99) >= 20);
        end
    end

    function automatic corner_t corner_at(int px, int py, int pz, int u, int v);
        corner_t c;
        c.pos_x = COORD_BITS'(px);
        c.pos_y = COORD_BITS'(py);
        c.pos_z = COORD_BITS'(pz);
        c.tex_u = COORD_BITS'(u);
        c.tex_v = COORD_BITS'(v);
        return c;
    endfunction

    function automatic int spread(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Offset a corner by random amounts in position and texture space
    function automatic corner_t near(corner_t base, int pspan, int tspan);
        return corner_at(int'(base.pos_x) + spread(pspan), int'(base.pos_y) + spread(pspan),
                         int'(base.pos_z) + spread(pspan), int'(base.tex_u) + spread(tspan),
                         int'(base.tex_v) + spread(tspan));
    endfunction

    // Present one corner, idling first at random, and hold it until transfer
    task automatic send_corner(corner_t c);
        if (!steady && $urandom_range(0, 99) < 20)
        begin
            corner_ch.valid <= 1'b0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(10, 50)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        corner_ch.valid <= 1'b1;
        corner_ch.pos_x <= c.pos_x;
        corner_ch.pos_y <= c.pos_y;
        corner_ch.pos_z <= c.pos_z;
        corner_ch.tex_u <= c.tex_u;
        corner_ch.tex_v <= c.tex_v;
        do
            @(posedge clk);
        while (!corner_ch.ready);
        sb.take_corner(c);
    endtask

    task automatic send_triangle(corner_t a, corner_t b, corner_t c);
        send_corner(a);
        send_corner(b);
        send_corner(c);
    endtask

    // Hold off the sender until every outstanding tangent has come back
    task automatic drain_tangents();
        corner_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic random_triangle();
        corner_t a;
        corner_t b;
        corner_t c;
        int      kind;
        kind = $urandom_range(0, 9);
        a = corner_at(spread(24000), spread(24000), spread(24000), spread(16000),
                      spread(16000));
        if (kind <= 2)
        begin
            // Full-range content
            a = corner_at(spread(32768), spread(32768), spread(32768), spread(32768),
                          spread(32768));
            b = corner_at(spread(32768), spread(32768), spread(32768), spread(32768),
                          spread(32768));
            c = corner_at(spread(32768), spread(32768), spread(32768), spread(32768),
                          spread(32768));
        end
        else if (kind <= 6)
        begin
            // Mesh-like triangle: nearby corners, modest UV spread
            b = near(a, 1024, 2048);
            c = near(a, 1024, 2048);
        end
        else if (kind == 7)
        begin
            // Zero determinant: repeated or collinear texture coordinates
            b = near(a, 1024, 2048);
            c = near(a, 1024, 0);
            case ($urandom_range(0, 2))
                0:
                begin
                    c.tex_u = a.tex_u;
                    c.tex_v = a.tex_v;
                end
                1:
                begin
                    c.tex_u = b.tex_u;
                    c.tex_v = b.tex_v;
                end
                default:
                begin
                    c.tex_u = COORD_BITS'(2 * int'(b.tex_u) - int'(a.tex_u));
                    c.tex_v = COORD_BITS'(2 * int'(b.tex_v) - int'(a.tex_v));
                end
            endcase
        end
        else if (kind == 8)
        begin
            // Large edges over tiny UV deltas: drive toward the rails
            a = corner_at(spread(32768), spread(32768), spread(32768), spread(16000),
                          spread(16000));
            b = corner_at(spread(32768), spread(32768), spread(32768),
                          int'(a.tex_u) + spread(3), int'(a.tex_v) + spread(3));
            c = corner_at(spread(32768), spread(32768), spread(32768),
                          int'(a.tex_u) + spread(3), int'(a.tex_v) + spread(3));
        end
        else
        begin
            // Coincident positions: zero numerators with a live determinant
            b = near(a, 0, 4096);
            c = near(a, 0, 4096);
        end
        send_triangle(a, b, c);
    endtask

    // Stimulus
    initial
    begin
        corner_ch.valid <= 1'b0;
        corner_ch.pos_x <= '0;
        corner_ch.pos_y <= '0;
        corner_ch.pos_z <= '0;
        corner_ch.tex_u <= '0;
        corner_ch.tex_v <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Tangent along x only, of length 1/16
        send_triangle(corner_at(0, 0, 0, 0, 0), corner_at(256, 0, 0, 4096, 0),
                      corner_at(0, 256, 0, 0, 4096));
        // Identical texture coordinates: degenerate
        send_triangle(corner_at(300, -200, 100, 1000, -1000),
                      corner_at(-50, 700, 9, 1000, -1000),
                      corner_at(12, 34, -56, 1000, -1000));
        // Coincident positions with a live determinant: zero tangent
        send_triangle(corner_at(0, 0, 0, 0, 0), corner_at(0, 0, 0, 4096, 0),
                      corner_at(0, 0, 0, 0, 4096));
        // Unit determinant, huge edges: both rails
        send_triangle(corner_at(-32768, 32767, 0, 0, 0), corner_at(32767, -32768, 5, 1, 0),
                      corner_at(0, 0, 0, 0, 1));
        // Quotients at exactly -2^31 and +2^31
        send_triangle(corner_at(0, 0, 0, 0, 0), corner_at(-2048, 2048, 2047, 1, 0),
                      corner_at(0, 0, 0, 0, 1));
        // Field extremes in every corner
        send_triangle(corner_at(32767, 32767, 32767, 32767, 32767),
                      corner_at(-32768, -32768, -32768, -32768, -32768),
                      corner_at(32767, -32768, 0, -32768, 32767));
        // Negative determinant with inexact quotients: truncate toward zero
        send_triangle(corner_at(0, 0, 0, 0, 0), corner_at(100, -100, 7, 3, 0),
                      corner_at(0, 0, 0, 0, -7));
        // Largest determinant magnitude
        send_triangle(corner_at(-32768, 32767, -32768, -32768, -32768),
                      corner_at(32767, -32768, 32767, 32767, -32768),
                      corner_at(32767, 32767, -32768, -32768, 32767));
        drain_tangents();

        for (int i = 0; i < 116; i++)
        begin
            if (i == 40)
            begin
                drain_tangents();
                steady <= 1'b1;
            end
            if (i == 70)
                steady <= 1'b0;
            if (i == 85)
                drain_tangents();
            random_triangle();
        end
        corner_ch.valid <= 1'b0;

        // Wait out the outstanding tangents, then watch for strays
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Covered %0d corners in %0d triangles: %0d degenerate, %0d on a rail.",
                 sb.corners, sb.triangles, sb.degenerate_count, sb.railed_count);
        $display("Compared %0d tangents field by field.", sb.checked);
        if (sb.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Timeout
    initial
    begin
        #3_000_000;
        $display("Timeout with %0d tangents outstanding.", sb.pending());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
